### src/hdwt_pkg.sv
// Shared types, constants and helpers for the 2D Haar forward transform core.
// No dependencies; every other file but hdwt_fifo refers to this package by scoped names.
`default_nettype none

package hdwt_pkg;

    // Default frame limits and queue depth
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int FIFO_DEPTH_DEF = 4;

    // Width of size arithmetic: covers 12-bit registers and limits up to 8192
    localparam int SIZE_W = 14;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1920;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd1080;

    // What the back end does with one request
    typedef enum logic [1:0] {
        OP_STORE_EVEN = 2'd0,  // top line, even column: write even bank
        OP_STORE_ODD  = 2'd1,  // top line, odd column: write odd bank
        OP_HOLD_LEFT  = 2'd2,  // bottom line, even column: keep as left pixel
        OP_EMIT       = 2'd3   // bottom line, odd column: close the 2x2 block
    } op_t;

    // One classified request (line store address travels beside it)
    typedef struct packed {
        op_t        op;
        logic [7:0] pixel;
        logic [9:0] block_row;
        logic [9:0] block_col;
        logic       frame_end;
    } cmd_t;

    // Address width of one line store bank (two banks, one per column parity)
    function automatic int bank_addr_width(input int max_width);
        int depth;
        depth = (max_width + 1) >> 1;
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Round down to even, raise to at least 2, cap at the limit
    function automatic logic [SIZE_W-1:0] eff_size(input logic [11:0] r,
                                                   input logic [SIZE_W-1:0] limit);
        logic [SIZE_W-1:0] v;
        v = {{(SIZE_W-12){1'b0}}, r[11:1], 1'b0};
        if (v < SIZE_W'(2)) begin
            v = SIZE_W'(2);
        end
        if (v > limit) begin
            v = limit;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### src/haar_dwt_2d_forward_core.sv
// One-level forward 2D Haar transform; a closing pixel request passes the queue,
// block stage and output register; one pixel per cycle unless the output stalls.
// A 2x2 block result appears for every odd-column pixel of an odd line.
// Line store: two single-port banks (even and odd columns), one access a cycle.
// Synchronous active-low reset clears counters and handshake state;
// configuration returns to 1920 x 1080 and the line store is not cleared.
`default_nettype none

module haar_dwt_2d_forward_core #(
    parameter int MAX_WIDTH  = hdwt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hdwt_pkg::MAX_HEIGHT_DEF,
    parameter int FIFO_DEPTH = hdwt_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_index,
    input  wire logic [11:0]  cfg_wr_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_pixel,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [9:0]        m_low_low,
    output logic signed [9:0] m_high_low,
    output logic signed [9:0] m_low_high,
    output logic signed [9:0] m_high_high,
    output logic [9:0]        m_block_row,
    output logic [9:0]        m_block_col,
    output logic              m_frame_end
);

    localparam int AW     = hdwt_pkg::bank_addr_width(MAX_WIDTH);
    localparam int CMD_W  = $bits(hdwt_pkg::cmd_t);
    localparam int DATA_W = CMD_W + AW;

    logic              push_valid, push_ready, pop_valid, pop_ready;
    hdwt_pkg::cmd_t    push_cmd, pop_cmd;
    logic [AW-1:0]     push_addr, pop_addr;
    logic [DATA_W-1:0] push_data, pop_data;

    hdwt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd),
        .push_addr   (push_addr)
    );

    // Pack request and bank address for the queue
    assign push_data = {push_cmd, push_addr};
    assign pop_cmd   = hdwt_pkg::cmd_t'(pop_data[DATA_W-1:AW]);
    assign pop_addr  = pop_data[AW-1:0];

    hdwt_fifo #(
        .DEPTH  (FIFO_DEPTH),
        .DATA_W (DATA_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hdwt_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .pop_addr    (pop_addr),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_low_low   (m_low_low),
        .m_high_low  (m_high_low),
        .m_low_high  (m_low_high),
        .m_high_high (m_high_high),
        .m_block_row (m_block_row),
        .m_block_col (m_block_col),
        .m_frame_end (m_frame_end)
    );

endmodule

`default_nettype wire

### src/hdwt_fifo.sv
// Small request queue between the front end and the back end.
// Generic payload vector; no package dependency beyond parameters.
`default_nettype none

module hdwt_fifo #(
    parameter int DEPTH  = 4,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("queue count not decremented on pop");

endmodule

`default_nettype wire

### src/hdwt_front.sv
// Front end: configuration registers, raster counters and request classification.
// Depends on hdwt_pkg (cmd_t, op_t, size helpers, register indexes).
`default_nettype none

module hdwt_front #(
    parameter int MAX_WIDTH  = hdwt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hdwt_pkg::MAX_HEIGHT_DEF,
    parameter int AW         = hdwt_pkg::bank_addr_width(MAX_WIDTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_index,
    input  wire logic [11:0]   cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_pixel,
    output logic               push_valid,
    input  wire logic          push_ready,
    output hdwt_pkg::cmd_t     push_cmd,
    output logic [AW-1:0]      push_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = hdwt_pkg::SIZE_W;

    logic [11:0]   frame_width_reg, frame_height_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] col_ext, row_ext, width_eff, height_eff;
    logic          line_last, frame_last, accept;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= hdwt_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= hdwt_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == hdwt_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_wr_data;
            end else begin
                frame_height_reg <= cfg_wr_data;
            end
        end
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // Find line and frame ends against the current register values
    assign col_ext    = SW'(col_reg);
    assign row_ext    = SW'(row_reg);
    assign width_eff  = hdwt_pkg::eff_size(frame_width_reg, SW'(MAX_WIDTH));
    assign height_eff = hdwt_pkg::eff_size(frame_height_reg, SW'(MAX_HEIGHT));
    assign line_last  = (col_ext + SW'(1)) >= width_eff;
    assign frame_last = line_last && ((row_ext + SW'(1)) >= height_eff);

    // Classify the pixel by row and column parity
    always_comb begin
        push_cmd.pixel     = s_pixel;
        push_cmd.block_row = row_ext[10:1];
        push_cmd.block_col = col_ext[10:1];
        push_cmd.frame_end = frame_last;
        case ({row_reg[0], col_reg[0]})
            2'b00:   push_cmd.op = hdwt_pkg::OP_STORE_EVEN;
            2'b01:   push_cmd.op = hdwt_pkg::OP_STORE_ODD;
            2'b10:   push_cmd.op = hdwt_pkg::OP_HOLD_LEFT;
            default: push_cmd.op = hdwt_pkg::OP_EMIT;
        endcase
    end
    assign push_addr = col_ext[AW:1];

    // Advance raster counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (line_last) begin
                col_next = '0;
                row_next = frame_last ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_ext < SW'(MAX_WIDTH)) && (row_ext < SW'(MAX_HEIGHT)))
        else $error("raster counter beyond frame limit");

endmodule

`default_nettype wire

### src/hdwt_back.sv
// Back end: line store banks, left pixel, butterfly and output register.
// Depends on hdwt_pkg (cmd_t, op_t, bank address width).
`default_nettype none

module hdwt_back #(
    parameter int MAX_WIDTH = hdwt_pkg::MAX_WIDTH_DEF,
    parameter int AW        = hdwt_pkg::bank_addr_width(MAX_WIDTH)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire hdwt_pkg::cmd_t  pop_cmd,
    input  wire logic [AW-1:0]   pop_addr,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [9:0]           m_low_low,
    output logic signed [9:0]    m_high_low,
    output logic signed [9:0]    m_low_high,
    output logic signed [9:0]    m_high_high,
    output logic [9:0]           m_block_row,
    output logic [9:0]           m_block_col,
    output logic                 m_frame_end
);

    localparam int BANK_DEPTH = (MAX_WIDTH + 1) >> 1;

    logic [7:0]  even_bank_reg [BANK_DEPTH];
    logic [7:0]  odd_bank_reg  [BANK_DEPTH];
    logic [7:0]  left_reg;
    logic [7:0]  top_a_reg, top_b_reg, s1_c_reg, s1_d_reg;
    logic [9:0]  s1_row_reg, s1_col_reg;
    logic        s1_end_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free, s1_free, pop_fire, emit_fire;
    logic signed [10:0] a_s, b_s, c_s, d_s;
    logic signed [10:0] ll_sum, hl_sum, lh_sum, hh_sum;

    // Handshake between queue, block stage and output register
    assign out_free  = !m_valid_reg || m_ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign pop_ready = (pop_cmd.op != hdwt_pkg::OP_EMIT) || s1_free;
    assign pop_fire  = pop_valid && pop_ready;
    assign emit_fire = pop_fire && (pop_cmd.op == hdwt_pkg::OP_EMIT);

    // Write line store banks; read both banks for a closing block
    always_ff @(posedge aclk) begin
        if (pop_fire && (pop_cmd.op == hdwt_pkg::OP_STORE_EVEN)) begin
            even_bank_reg[pop_addr] <= pop_cmd.pixel;
        end
        if (pop_fire && (pop_cmd.op == hdwt_pkg::OP_STORE_ODD)) begin
            odd_bank_reg[pop_addr] <= pop_cmd.pixel;
        end
        if (emit_fire) begin
            top_a_reg <= even_bank_reg[pop_addr];
            top_b_reg <= odd_bank_reg[pop_addr];
        end
    end

    // Hold the left pixel of the bottom line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (pop_fire && (pop_cmd.op == hdwt_pkg::OP_HOLD_LEFT)) begin
            left_reg <= pop_cmd.pixel;
        end
    end

    // Capture the bottom pair and block position
    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            s1_c_reg   <= left_reg;
            s1_d_reg   <= pop_cmd.pixel;
            s1_row_reg <= pop_cmd.block_row;
            s1_col_reg <= pop_cmd.block_col;
            s1_end_reg <= pop_cmd.frame_end;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (emit_fire) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = out_free ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Butterfly over the 2x2 block
    assign a_s    = signed'({3'b000, top_a_reg});
    assign b_s    = signed'({3'b000, top_b_reg});
    assign c_s    = signed'({3'b000, s1_c_reg});
    assign d_s    = signed'({3'b000, s1_d_reg});
    assign ll_sum = (a_s + b_s) + (c_s + d_s);
    assign hl_sum = (b_s + d_s) - (a_s + c_s);
    assign lh_sum = (c_s + d_s) - (a_s + b_s);
    assign hh_sum = (a_s + d_s) - (b_s + c_s);

    // Load the output register
    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            m_low_low   <= ll_sum[9:0];
            m_high_low  <= hl_sum[9:0];
            m_low_high  <= lh_sum[9:0];
            m_high_high <= hh_sum[9:0];
            m_block_row <= s1_row_reg;
            m_block_col <= s1_col_reg;
            m_frame_end <= s1_end_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("block stage dropped while output stalled");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && s1_valid_reg) |-> !emit_fire)
        else $error("block request taken with no room downstream");

endmodule

`default_nettype wire

### test/tb_haar_dwt_2d_forward_core.sv
// Self-checking testbench for haar_dwt_2d_forward_core: directed 2x2 blocks,
// then random frames of random size against an in-bench transform predictor.
// Depends on hdwt_pkg (src/hdwt_pkg.sv) and the core (src/haar_dwt_2d_forward_core.sv).
`default_nettype none

module tb_haar_dwt_2d_forward_core;

    localparam int MAX_W        = hdwt_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H        = hdwt_pkg::MAX_HEIGHT_DEF;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PIPE_DRAIN   = 8;
    localparam int LIMIT_CYCLES = 1_000_000;

    // One block result: doubled subband coefficients and block position
    typedef struct packed {
        logic [9:0]        low_low;
        logic signed [9:0] high_low;
        logic signed [9:0] low_high;
        logic signed [9:0] high_high;
        logic [9:0]        block_row;
        logic [9:0]        block_col;
        logic              frame_end;
    } haar_block_t;

    // One directed step: a register write, or a pixel with an optional fixed result
    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [11:0] cfg_val;
        logic [7:0]  px;
        bit          fixed;
        haar_block_t want;
    } script_row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_index   = hdwt_pkg::REG_FRAME_WIDTH;
    logic [11:0] cfg_wr_data = 12'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_pixel     = 8'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [9:0]        m_low_low;
    logic signed [9:0] m_high_low;
    logic signed [9:0] m_low_high;
    logic signed [9:0] m_high_high;
    logic [9:0]        m_block_row;
    logic [9:0]        m_block_col;
    logic              m_frame_end;

    // Predictor state
    logic [7:0]  top_line [0:MAX_W-1];
    logic [7:0]  left_px    = 8'd0;
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    logic [11:0] width_reg  = hdwt_pkg::FRAME_WIDTH_RST;
    logic [11:0] height_reg = hdwt_pkg::FRAME_HEIGHT_RST;

    haar_block_t pending_blocks [$];
    script_row_t script [$];
    int          mismatches  = 0;
    int unsigned pixels_fed  = 0;
    int unsigned cycle_count = 0;
    bit          src_steady  = 1'b0;
    bit          sink_steady = 1'b0;

    haar_dwt_2d_forward_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_low_low   (m_low_low),
        .m_high_low  (m_high_low),
        .m_low_high  (m_low_high),
        .m_high_high (m_high_high),
        .m_block_row (m_block_row),
        .m_block_col (m_block_col),
        .m_frame_end (m_frame_end)
    );

    always #5 aclk = ~aclk;

    // Frame dimension in use: even, at least 2, capped
    function automatic int unsigned span(input logic [11:0] r, input int unsigned cap);
        int unsigned v;
        v = {r[11:1], 1'b0};
        if (v < 2) begin
            v = 2;
        end
        if (v > cap) begin
            v = cap;
        end
        return v;
    endfunction

    // Advance the predictor by one pixel; return 1 when a 2x2 block closes
    function automatic bit transform_pixel(input logic [7:0] px, output haar_block_t blk);
        int unsigned w, h;
        int          a, b, c, d;
        bit          eol, eof, hit;
        w   = span(width_reg, MAX_W);
        h   = span(height_reg, MAX_H);
        eol = (col_pos + 1 >= w);
        eof = eol && (row_pos + 1 >= h);
        hit = 1'b0;
        blk = '0;
        if (row_pos[0] == 1'b0) begin
            top_line[col_pos] = px;
        end else if (col_pos[0] == 1'b0) begin
            left_px = px;
        end else begin
            a = top_line[col_pos - 1];
            b = top_line[col_pos];
            c = left_px;
            d = px;
            blk.low_low   = 10'(a + b + c + d);
            blk.high_low  = 10'(b - a + d - c);
            blk.low_high  = 10'(c + d - a - b);
            blk.high_high = 10'(a - b - c + d);
            blk.block_row = 10'(row_pos >> 1);
            blk.block_col = 10'(col_pos >> 1);
            blk.frame_end = eof;
            hit = 1'b1;
        end
        if (eol) begin
            col_pos = 0;
            row_pos = eof ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return hit;
    endfunction

    function automatic haar_block_t mk_block(input int ll, input int hl, input int lh,
                                             input int hh, input int br, input int bc,
                                             input int fe);
        haar_block_t r;
        r.low_low   = 10'(ll);
        r.high_low  = 10'(hl);
        r.low_high  = 10'(lh);
        r.high_high = 10'(hh);
        r.block_row = 10'(br);
        r.block_col = 10'(bc);
        r.frame_end = 1'(fe);
        return r;
    endfunction

    // Mostly uniform pixels, with the extremes favored
    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_cfg(input logic idx, input logic [11:0] val);
        script_row_t r;
        r = '{is_cfg: 1'b1, cfg_idx: idx, cfg_val: val, px: 8'd0, fixed: 1'b0, want: '0};
        script.push_back(r);
    endtask

    task automatic add_px(input logic [7:0] px, input bit fixed, input haar_block_t want);
        script_row_t r;
        r = '{is_cfg: 1'b0, cfg_idx: 1'b0, cfg_val: 12'd0, px: px, fixed: fixed, want: want};
        script.push_back(r);
    endtask

    // Four pixels of a two-wide frame close one block: a, b on top, c, d below
    task automatic add_block(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                             input logic [7:0] d, input haar_block_t want);
        add_px(a, 1'b0, '0);
        add_px(b, 1'b0, '0);
        add_px(c, 1'b0, '0);
        add_px(d, 1'b1, want);
    endtask

    task automatic build_script();
        // Two-wide frame (width 1 rounds up), height left at its reset value
        add_cfg(hdwt_pkg::REG_FRAME_WIDTH, 12'd1);
        add_block(8'd255, 8'd255, 8'd255, 8'd255, mk_block(1020, 0, 0, 0, 0, 0, 0));
        add_block(8'd0, 8'd255, 8'd0, 8'd255, mk_block(510, 510, 0, 0, 1, 0, 0));
        add_block(8'd255, 8'd0, 8'd255, 8'd0, mk_block(510, -510, 0, 0, 2, 0, 0));
        add_block(8'd0, 8'd0, 8'd255, 8'd255, mk_block(510, 0, 510, 0, 3, 0, 0));
        add_block(8'd255, 8'd255, 8'd0, 8'd0, mk_block(510, 0, -510, 0, 4, 0, 0));
        add_block(8'd255, 8'd0, 8'd0, 8'd255, mk_block(510, 0, 0, 510, 5, 0, 0));
        add_block(8'd0, 8'd255, 8'd255, 8'd0, mk_block(510, 0, 0, -510, 6, 0, 0));
        // Shrink height mid-frame: the frame closes on a top line, no block
        add_cfg(hdwt_pkg::REG_FRAME_HEIGHT, 12'd0);
        add_px(8'h5A, 1'b0, '0);
        add_px(8'hA5, 1'b0, '0);
        // Odd width rounds down to 6; all-zero block gives the low extreme
        add_cfg(hdwt_pkg::REG_FRAME_WIDTH, 12'd7);
        repeat (7) add_px(8'd0, 1'b0, '0);
        add_px(8'd0, 1'b1, mk_block(0, 0, 0, 0, 0, 0, 0));
        // Narrow mid-line so an even-column pixel ends the line and the frame
        add_cfg(hdwt_pkg::REG_FRAME_WIDTH, 12'd3);
        add_px(8'd77, 1'b0, '0);
    endtask

    // Offer one pixel and hold it until the core takes it
    task automatic send_pixel(input logic [7:0] px);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pixels_fed++;
        if ($urandom_range(0, 47) == 0) begin
            src_steady = !src_steady;
        end
    endtask

    task automatic feed_pixel(input logic [7:0] px);
        haar_block_t blk;
        send_pixel(px);
        if (transform_pixel(px, blk)) begin
            pending_blocks.push_back(blk);
        end
    endtask

    // Feed random pixels until the raster returns to the top-left corner
    task automatic finish_frame();
        do feed_pixel(rand_pixel()); while (col_pos != 0 || row_pos != 0);
    endtask

    // Drop valid, wait for every pending block, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == hdwt_pkg::REG_FRAME_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val;
        end
    endtask

    task automatic check_field(input string name, input logic signed [10:0] want,
                               input logic signed [10:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Sender side: reset, directed table, random frames
    initial begin : stimulus
        haar_block_t blk;
        bit          made;
        int unsigned wr, hr, n, random_base;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        build_script();
        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            end else begin
                send_pixel(script[i].px);
                made = transform_pixel(script[i].px, blk);
                if (script[i].fixed) begin
                    pending_blocks.push_back(script[i].want);
                end else if (made) begin
                    pending_blocks.push_back(blk);
                end
            end
        end

        // Random small frames; mid-frame only narrow the width
        random_base = pixels_fed;
        while (pixels_fed - random_base < RANDOM_ITEMS) begin
            settle();
            if (col_pos == 0 && row_pos == 0) begin
                wr = $urandom_range(0, 21);
            end else begin
                wr = $urandom_range(0, span(width_reg, MAX_W) + 1);
            end
            hr = $urandom_range(0, 11);
            if ($urandom_range(0, 3) != 0) begin
                write_reg(hdwt_pkg::REG_FRAME_WIDTH, 12'(wr));
            end
            if ($urandom_range(0, 3) != 0) begin
                write_reg(hdwt_pkg::REG_FRAME_HEIGHT, 12'(hr));
            end
            if (col_pos != 0 || row_pos != 0) begin
                finish_frame();
            end
            repeat ($urandom_range(1, 3)) finish_frame();
            if ($urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, span(width_reg, MAX_W) * span(height_reg, MAX_H) - 1);
                repeat (n) feed_pixel(rand_pixel());
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("** haar_dwt_2d_forward_core: PASSED **");
        end else begin
            $display("** haar_dwt_2d_forward_core: FAILED **");
        end
        $finish;
    end

    // Receiver side: before each block, drop ready for a random stall unless in steady mode
    initial begin : sink
        int stall;
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if ($urandom_range(0, 47) == 0) begin
                sink_steady = !sink_steady;
            end
        end
    end

    // Compare each taken block with the oldest pending one
    always @(posedge aclk) begin : result_check
        haar_block_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_blocks.size() == 0) begin
                $error("block result with none pending: row %0d col %0d",
                       m_block_row, m_block_col);
                mismatches++;
            end else begin
                want = pending_blocks.pop_front();
                check_field("low_low", 11'(want.low_low), 11'(m_low_low));
                check_field("high_low", 11'(want.high_low), 11'(m_high_low));
                check_field("low_high", 11'(want.low_high), 11'(m_low_high));
                check_field("high_high", 11'(want.high_high), 11'(m_high_high));
                check_field("block_row", 11'(want.block_row), 11'(m_block_row));
                check_field("block_col", 11'(want.block_col), 11'(m_block_col));
                check_field("frame_end", 11'(want.frame_end), 11'(m_frame_end));
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** haar_dwt_2d_forward_core: FAILED **");
            $finish;
        end
    end

endmodule

`default_nettype wire
